// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker property file
// Clocked concurrent assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is held.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/tesc_pkg.sv =====
// ----------------------------------------------------------------------------
// tesc_pkg
// Types and constants for the TDC event stream checker.
// ----------------------------------------------------------------------------
package tesc_pkg;

    localparam int KIND_W   = 4;
    localparam int GEO_W    = 5;
    localparam int EVT_W    = 22;
    localparam int CHIP_W   = 2;
    localparam int TAG_W    = 12;
    localparam int COUNT_W  = 16;
    localparam int STAT_W   = 3;
    localparam int ERR_W    = 15;
    localparam int CHIDX_W  = 3;

    // Word kinds; codes from 8 upwards are unknown
    localparam logic [KIND_W-1:0] KIND_GLOBAL_HDR  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_GLOBAL_TRL  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_TDC_HDR     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_MEASUREMENT = 4'd3;
    localparam logic [KIND_W-1:0] KIND_TDC_TRL     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_TDC_ERROR   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_TIME_TAG    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_FILLER      = 4'd7;

    typedef struct packed {
        logic [KIND_W-1:0]  word_kind;
        logic [GEO_W-1:0]   geo_addr;
        logic [EVT_W-1:0]   event_number;
        logic [CHIP_W-1:0]  chip_number;
        logic [TAG_W-1:0]   event_tag;
        logic [COUNT_W-1:0] count_field;
        logic [STAT_W-1:0]  trailer_status;
        logic [ERR_W-1:0]   error_bits;
    } word_t;

    typedef struct packed {
        logic               count_jump;
        logic               geo_changed;
        logic               misplaced;
        logic [STAT_W-1:0]  status_bits;
        logic               geo_mismatch;
        logic               length_mismatch;
        logic               chip_mismatch;
        logic               tag_mismatch;
        logic [ERR_W-1:0]   chip_errors;
        logic               event_done;
        logic               scan_stop;
        logic               unknown_word;
    } flags_t;

    typedef struct packed {
        logic               inside_event;
        logic               inside_chip_block;
        logic               addr_known;
        logic [GEO_W-1:0]   saved_geo;
        logic               number_known;
        logic [EVT_W-1:0]   saved_event;
        logic [CHIDX_W-1:0] chip_index;
        logic [COUNT_W-1:0] word_position;
        logic [COUNT_W-1:0] block_start;
    } track_t;

endpackage

// ===== sv/tdc_event_stream_checker_core.sv =====
// ----------------------------------------------------------------------------
// tdc_event_stream_checker_core
// Frame checker for a stream of decoded TDC readout words.
// ----------------------------------------------------------------------------
// Every accepted input beat (one decoded readout word) yields exactly one
// output beat of check flags, in order. The block runs at one word per clock
// cycle unless out_ready holds it off: a word is registered on entry, checked
// against the tracking state by a single pass of compare-and-count logic,
// and its flags are registered on exit, so a result passes through the entry
// register and then the exit register before out_valid rises. The
// tracking state (inside-event and inside-TDC-block flags, last event count,
// module address, TDC index, word positions) is updated in the same cycle the
// flags are captured, so back-to-back words see each other's effects. The
// entry and exit registers decouple the two channels: a new word is taken
// while a finished result waits for out_ready, and the block only stalls its
// input once both registers hold a beat. No configuration; reset returns the
// tracking state to "outside any event, nothing yet seen".
// ----------------------------------------------------------------------------
module tdc_event_stream_checker_core
    import tesc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  word_t  in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output flags_t out_data
);

    // entry register
    logic   stage_valid_reg;
    logic   stage_valid_next;
    word_t  stage_data_reg;

    // exit register
    logic   out_valid_reg;
    logic   out_valid_next;
    flags_t out_data_reg;

    // tracking state
    track_t track_reg;
    track_t track_next;
    track_t track_step;
    flags_t flags;

    logic   advance;
    logic   take;

    // The exit register can accept a new result when it is empty or draining.
    assign advance  = !out_valid_reg || out_ready;
    // The entry register frees up when it is empty or moving forward.
    assign in_ready = !stage_valid_reg || advance;
    assign take     = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tesc_step u_step
    (
        .track      (track_reg),
        .word       (stage_data_reg),
        .track_next (track_step),
        .flags      (flags)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        out_valid_next   = out_valid_reg;
        track_next       = track_reg;
        if (in_ready)
            stage_valid_next = in_valid;
        if (advance)
        begin
            out_valid_next = stage_valid_reg;
            // commit the state change only for the word actually moving out
            if (stage_valid_reg)
                track_next = track_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            track_reg       <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            track_reg       <= track_next;
        end
    end

    // payload: hold unless a beat moves in
    always_ff @(posedge clk)
    begin
        if (take)
            stage_data_reg <= in_data;
        if (advance && stage_valid_reg)
            out_data_reg <= flags;
    end

endmodule

// ===== sv/tesc_step.sv =====
// ----------------------------------------------------------------------------
// tesc_step
// Check one readout word against the frame tracking state and form the
// flags and the next tracking state.
// ----------------------------------------------------------------------------
module tesc_step
    import tesc_pkg::*;
(
    input  track_t track,
    input  word_t  word,
    output track_t track_next,
    output flags_t flags
);

    logic [COUNT_W-1:0] wc;
    logic [COUNT_W-1:0] wc_inc;
    logic               chip_bad;
    logic               tag_bad;

    assign wc       = track.word_position;
    assign wc_inc   = wc + COUNT_W'(1);
    assign chip_bad = {1'b0, word.chip_number} != track.chip_index;
    assign tag_bad  = word.event_tag != track.saved_event[TAG_W-1:0];

    always_comb
    begin
        flags      = '0;
        track_next = track;
        if (!track.inside_event)
        begin
            priority if (word.word_kind == KIND_GLOBAL_HDR)
            begin
                if (track.number_known)
                    flags.count_jump = word.event_number != (track.saved_event + EVT_W'(1));
                if (track.addr_known)
                    flags.geo_changed = word.geo_addr != track.saved_geo;
                track_next.saved_event       = word.event_number;
                track_next.number_known      = 1'b1;
                track_next.saved_geo         = word.geo_addr;
                track_next.addr_known        = 1'b1;
                track_next.inside_event      = 1'b1;
                track_next.inside_chip_block = 1'b0;
                track_next.chip_index        = '0;
                track_next.word_position     = COUNT_W'(1);
            end
            else if (word.word_kind == KIND_FILLER)
            begin
                flags.scan_stop = 1'b1;
            end
            else if (word.word_kind[KIND_W-1])
            begin
                flags.scan_stop    = 1'b1;
                flags.unknown_word = 1'b1;
            end
            else
            begin
                flags.misplaced = 1'b1;
            end
        end
        else
        begin
            unique case (word.word_kind)
                KIND_GLOBAL_HDR:
                begin
                    flags.misplaced = 1'b1;
                end
                KIND_GLOBAL_TRL:
                begin
                    flags.misplaced              = track.inside_chip_block;
                    flags.status_bits            = word.trailer_status;
                    flags.geo_mismatch           = word.geo_addr != track.saved_geo;
                    flags.length_mismatch        = word.count_field != wc_inc;
                    flags.event_done             = 1'b1;
                    track_next.inside_event      = 1'b0;
                    track_next.inside_chip_block = 1'b0;
                end
                KIND_TDC_HDR:
                begin
                    flags.misplaced              = track.inside_chip_block;
                    flags.chip_mismatch          = chip_bad;
                    flags.tag_mismatch           = tag_bad;
                    track_next.inside_chip_block = 1'b1;
                    track_next.block_start       = wc;
                end
                KIND_MEASUREMENT:
                begin
                    flags.misplaced = !track.inside_chip_block;
                end
                KIND_TDC_TRL:
                begin
                    flags.misplaced              = !track.inside_chip_block;
                    flags.chip_mismatch          = chip_bad;
                    flags.tag_mismatch           = tag_bad;
                    flags.length_mismatch        =
                        word.count_field != (wc - track.block_start + COUNT_W'(1));
                    track_next.chip_index        = track.chip_index + CHIDX_W'(1);
                    track_next.inside_chip_block = 1'b0;
                end
                KIND_TDC_ERROR:
                begin
                    flags.chip_errors = word.error_bits;
                end
                KIND_TIME_TAG:
                begin
                    flags = '0;
                end
                KIND_FILLER:
                begin
                    flags.misplaced = 1'b1;
                end
                default:
                begin
                    flags.event_done             = 1'b1;
                    flags.unknown_word           = 1'b1;
                    track_next.inside_event      = 1'b0;
                    track_next.inside_chip_block = 1'b0;
                end
            endcase
            // advance the word position only while the event stays open
            if (track_next.inside_event)
                track_next.word_position = wc_inc;
        end
    end

endmodule

// ===== sv/tesc_props.sv =====
// ----------------------------------------------------------------------------
// tesc_props
// Port-level checks for the TDC event stream checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tesc_props
    import tesc_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input flags_t out_data
);

    logic out_stall;
    logic status_seen;
    logic stop_seen;
    logic stop_mixed;
    logic unknown_seen;
    logic one_ending;

    assign out_stall    = out_valid && !out_ready;
    assign status_seen  = out_valid && (out_data.status_bits != '0);
    assign stop_seen    = out_valid && out_data.scan_stop;
    assign stop_mixed   = out_data.event_done || out_data.misplaced || out_data.count_jump
                          || (out_data.chip_errors != '0);
    assign unknown_seen = out_valid && out_data.unknown_word;
    assign one_ending   = out_data.event_done ^ out_data.scan_stop;

    // hold a stalled result beat
    `ASSERT_AT(a_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data), "beat changed")

    // trailer status only appears on a closing global trailer
    `ASSERT_IMPLY(a_status_end, clk, rst_n, status_seen, out_data.event_done, "stray status")

    // an end of scan never coincides with frame checks
    `ASSERT_IMPLY(a_stop_alone, clk, rst_n, stop_seen, !stop_mixed, "scan stop mixed")

    // an unknown word either closes the event or ends the scan
    `ASSERT_IMPLY(a_unknown_ends, clk, rst_n, unknown_seen, one_ending, "unknown word not ended")

    // an empty exit register never holds off the input
    `ASSERT_IMPLY(a_in_free, clk, rst_n, in_valid && !out_valid, in_ready, "input stalled")

endmodule

bind tdc_event_stream_checker_core tesc_props u_tesc_props (.*);

// ===== verif/tesc_checker.sv =====
// ----------------------------------------------------------------------------
// tesc_checker
// Watches both channels of the TDC event stream checker and scores its flags.
// Each input beat is run through a local model of the frame tracking, and
// the flags it should produce are queued. Each output beat is then compared,
// field by field, with the oldest queued set.
// ----------------------------------------------------------------------------
module tesc_checker
    import tesc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_ready,
    input  word_t  in_data,
    input  logic   out_valid,
    input  logic   out_ready,
    input  flags_t out_data,
    output int     errors,
    output int     waiting,
    output int     checked
);

    track_t frame_state;
    flags_t flags_due[$];

    // Work out the flags for one word and advance the frame tracking.
    function automatic flags_t judge_word(input word_t w);
        flags_t             f;
        logic [COUNT_W-1:0] pos;
        f   = '0;
        pos = frame_state.word_position;
        if (!frame_state.inside_event) begin
            if (w.word_kind == KIND_GLOBAL_HDR) begin
                if (frame_state.number_known)
                    f.count_jump = (w.event_number != EVT_W'(frame_state.saved_event + 1));
                if (frame_state.addr_known)
                    f.geo_changed = (w.geo_addr != frame_state.saved_geo);
                frame_state.saved_event       = w.event_number;
                frame_state.number_known      = 1'b1;
                frame_state.saved_geo         = w.geo_addr;
                frame_state.addr_known        = 1'b1;
                frame_state.inside_event      = 1'b1;
                frame_state.inside_chip_block = 1'b0;
                frame_state.chip_index        = '0;
                frame_state.word_position     = COUNT_W'(1);
            end else if (w.word_kind == KIND_FILLER) begin
                f.scan_stop = 1'b1;
            end else if (w.word_kind > KIND_FILLER) begin
                f.scan_stop    = 1'b1;
                f.unknown_word = 1'b1;
            end else begin
                f.misplaced = 1'b1;
            end
        end else begin
            case (w.word_kind)
                KIND_GLOBAL_HDR: f.misplaced = 1'b1;
                KIND_GLOBAL_TRL: begin
                    f.misplaced       = frame_state.inside_chip_block;
                    f.status_bits     = w.trailer_status;
                    f.geo_mismatch    = (w.geo_addr != frame_state.saved_geo);
                    f.length_mismatch = (w.count_field != COUNT_W'(pos + 1));
                    f.event_done      = 1'b1;
                    frame_state.inside_event      = 1'b0;
                    frame_state.inside_chip_block = 1'b0;
                end
                KIND_TDC_HDR: begin
                    f.misplaced     = frame_state.inside_chip_block;
                    f.chip_mismatch = ({1'b0, w.chip_number} != frame_state.chip_index);
                    f.tag_mismatch  = (w.event_tag != frame_state.saved_event[TAG_W-1:0]);
                    frame_state.inside_chip_block = 1'b1;
                    frame_state.block_start       = pos;
                end
                KIND_MEASUREMENT: f.misplaced = !frame_state.inside_chip_block;
                KIND_TDC_TRL: begin
                    f.misplaced       = !frame_state.inside_chip_block;
                    f.chip_mismatch   = ({1'b0, w.chip_number} != frame_state.chip_index);
                    f.tag_mismatch    = (w.event_tag != frame_state.saved_event[TAG_W-1:0]);
                    f.length_mismatch = (w.count_field !=
                                         COUNT_W'(pos - frame_state.block_start + 1));
                    frame_state.chip_index        = CHIDX_W'(frame_state.chip_index + 1);
                    frame_state.inside_chip_block = 1'b0;
                end
                KIND_TDC_ERROR: f.chip_errors = w.error_bits;
                KIND_TIME_TAG:  ;
                KIND_FILLER:    f.misplaced = 1'b1;
                default: begin
                    f.event_done   = 1'b1;
                    f.unknown_word = 1'b1;
                    frame_state.inside_event      = 1'b0;
                    frame_state.inside_chip_block = 1'b0;
                end
            endcase
            if (frame_state.inside_event)
                frame_state.word_position = COUNT_W'(pos + 1);
        end
        return f;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t checker: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    initial begin
        errors  = 0;
        waiting = 0;
        checked = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        flags_t want;
        if (!rst_n) begin
            frame_state = '0;
            flags_due.delete();
        end else begin
            if (in_valid && in_ready)
                flags_due.push_back(judge_word(in_data));
            if (out_valid && out_ready) begin
                if (flags_due.size() == 0) begin
                    errors++;
                    $display("%0t checker: unexpected beat, expected none got %0h",
                             $time, out_data);
                end else begin
                    want = flags_due.pop_front();
                    checked++;
                    compare_field("count_jump", want.count_jump, out_data.count_jump);
                    compare_field("geo_changed", want.geo_changed, out_data.geo_changed);
                    compare_field("misplaced", want.misplaced, out_data.misplaced);
                    compare_field("status_bits", want.status_bits, out_data.status_bits);
                    compare_field("geo_mismatch", want.geo_mismatch, out_data.geo_mismatch);
                    compare_field("length_mismatch", want.length_mismatch,
                                  out_data.length_mismatch);
                    compare_field("chip_mismatch", want.chip_mismatch, out_data.chip_mismatch);
                    compare_field("tag_mismatch", want.tag_mismatch, out_data.tag_mismatch);
                    compare_field("chip_errors", want.chip_errors, out_data.chip_errors);
                    compare_field("event_done", want.event_done, out_data.event_done);
                    compare_field("scan_stop", want.scan_stop, out_data.scan_stop);
                    compare_field("unknown_word", want.unknown_word, out_data.unknown_word);
                end
            end
            waiting = flags_due.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TDC event stream checker.
// Drives a short directed frame sequence through the block, then mostly
// well-formed events with random content mixed with noise and damaged
// events.
// Scoring is left to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import tesc_pkg::*;

    // Kind codes from 8 upwards are all unknown; keep both ends to hand
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 4'd8;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 4'd15;

    localparam int RANDOM_WORDS = 1400;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 4000000;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_ready;
    word_t  in_data   = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    flags_t out_data;

    int fault_count;
    int still_due;
    int beats_checked;

    // hold_asks is shared between the stimulus and the receiver: each ask is one long hold-off
    int hold_asks   = 0;
    int burst_left  = 0;
    int words_sent  = 0;
    int events_sent = 0;
    int cycles      = 0;

    logic [EVT_W-1:0] next_evn = '0;
    logic [GEO_W-1:0] cur_geo  = '0;

    always #10 clk = ~clk;

    tdc_event_stream_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tesc_checker scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (fault_count),
        .waiting   (still_due),
        .checked   (beats_checked)
    );

    // Fill every field with noise, then set the kind. Callers overwrite the
    // fields that matter for that kind, so the rest keeps every bit moving.
    function automatic word_t raw_word(input logic [KIND_W-1:0] kind);
        word_t w;
        w.word_kind      = kind;
        w.geo_addr       = GEO_W'($urandom);
        w.event_number   = EVT_W'($urandom);
        w.chip_number    = CHIP_W'($urandom);
        w.event_tag      = TAG_W'($urandom);
        w.count_field    = COUNT_W'($urandom);
        w.trailer_status = STAT_W'($urandom);
        w.error_bits     = ERR_W'($urandom);
        return w;
    endfunction

    // Present one beat and hold it until the block takes it. The sender
    // works in bursts; between bursts valid may drop for a random gap. Called
    // just after a rising edge, and returns just after the accepting edge.
    task automatic offer(input word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // Now and then a long burst, so some stretches carry no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // Build one event frame: global header, a few TDC blocks, global trailer.
    // Counts, tags and chip numbers are right most of the time. A damaged
    // event gets a stray word, a missing word or an unknown word for a tail.
    task automatic send_event(input bit damaged);
        word_t            frame[$];
        word_t            w;
        logic [EVT_W-1:0] evn;
        int               blocks;
        int               hdr_at;
        int               spot;
        int               kind_pick;
        evn = ($urandom_range(0, 15) == 0) ? EVT_W'($urandom) : next_evn;
        if ($urandom_range(0, 15) == 0)
            cur_geo = GEO_W'($urandom);
        w = raw_word(KIND_GLOBAL_HDR);
        w.event_number = evn;
        w.geo_addr     = cur_geo;
        frame.push_back(w);
        // Mostly up to four blocks; sometimes more, to run the chip index past 3
        blocks = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
        for (int b = 0; b < blocks; b++) begin
            if ($urandom_range(0, 3) == 0)
                frame.push_back(raw_word($urandom_range(0, 1) ? KIND_TIME_TAG
                                                              : KIND_TDC_ERROR));
            hdr_at = frame.size();
            w = raw_word(KIND_TDC_HDR);
            w.chip_number = ($urandom_range(0, 15) == 0) ? CHIP_W'($urandom) : CHIP_W'(b);
            w.event_tag   = ($urandom_range(0, 15) == 0) ? TAG_W'($urandom) : evn[TAG_W-1:0];
            frame.push_back(w);
            repeat ($urandom_range(0, 6)) begin
                kind_pick = $urandom_range(0, 5);
                frame.push_back(raw_word((kind_pick < 4)  ? KIND_MEASUREMENT :
                                         (kind_pick == 4) ? KIND_TDC_ERROR : KIND_TIME_TAG));
            end
            w = raw_word(KIND_TDC_TRL);
            w.chip_number = ($urandom_range(0, 15) == 0) ? CHIP_W'($urandom) : CHIP_W'(b);
            w.event_tag   = ($urandom_range(0, 15) == 0) ? TAG_W'($urandom) : evn[TAG_W-1:0];
            // Block length counts its own header and trailer
            w.count_field = ($urandom_range(0, 15) == 0) ? COUNT_W'($urandom)
                                                         : COUNT_W'(frame.size() - hdr_at + 1);
            frame.push_back(w);
        end
        w = raw_word(KIND_GLOBAL_TRL);
        w.geo_addr       = ($urandom_range(0, 15) == 0) ? GEO_W'($urandom) : cur_geo;
        w.count_field    = ($urandom_range(0, 15) == 0) ? COUNT_W'($urandom)
                                                        : COUNT_W'(frame.size() + 1);
        w.trailer_status = ($urandom_range(0, 3) == 0) ? STAT_W'($urandom) : '0;
        frame.push_back(w);
        if (damaged) begin
            spot = $urandom_range(1, frame.size() - 1);
            case ($urandom_range(0, 2))
                0: frame.insert(spot, raw_word(KIND_W'($urandom)));
                1: frame.delete(spot);
                default: frame[frame.size() - 1] =
                    raw_word(KIND_W'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI)));
            endcase
        end
        next_evn = EVT_W'(evn + 1);
        foreach (frame[i]) offer(frame[i]);
        events_sent++;
    endtask

    // Watchdog: end the run if the traffic never drains
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: change stall mode every so often; serve each hold-off ask
    // with a long stretch of ready low, counted here, so the block fills up.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int holds_served;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_asks) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cycles % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        word_t w;
        int    base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Outside any event: filler and unknown stop the scan,
        // anything else but a header is misplaced.
        offer(raw_word(KIND_FILLER));
        offer(raw_word(KIND_UNKNOWN_HI));
        offer(raw_word(KIND_MEASUREMENT));
        offer(raw_word(KIND_GLOBAL_TRL));
        // First header ever, top count and address: nothing to compare yet
        w = raw_word(KIND_GLOBAL_HDR);
        w.event_number = '1;
        w.geo_addr     = '1;
        offer(w);
        // Second header inside the event is misplaced
        offer(raw_word(KIND_GLOBAL_HDR));
        // TDC trailer with no header open; length against the reset block start
        w = raw_word(KIND_TDC_TRL);
        w.chip_number = '0;
        w.event_tag   = '1;
        w.count_field = '1;
        offer(w);
        // Header with the wrong chip number, then a nested header
        w = raw_word(KIND_TDC_HDR);
        w.chip_number = '1;
        w.event_tag   = '1;
        offer(w);
        offer(raw_word(KIND_TDC_HDR));
        offer(raw_word(KIND_MEASUREMENT));
        w = raw_word(KIND_TDC_ERROR);
        w.error_bits = '1;
        offer(w);
        offer(raw_word(KIND_TIME_TAG));
        // Filler inside an event is misplaced but the event carries on
        offer(raw_word(KIND_FILLER));
        // Global trailer while a block is still open, all status bits set
        w = raw_word(KIND_GLOBAL_TRL);
        w.trailer_status = '1;
        w.geo_addr       = '0;
        w.count_field    = '0;
        offer(w);
        // Count wraps from the top to zero: no jump; address changes
        w = raw_word(KIND_GLOBAL_HDR);
        w.event_number = '0;
        w.geo_addr     = '0;
        offer(w);
        offer(raw_word(KIND_MEASUREMENT));
        // Unknown word inside an event closes it
        offer(raw_word(KIND_UNKNOWN_LO));
        offer(raw_word(KIND_FILLER));
        // Jumped count and changed address, then one clean block and trailer
        w = raw_word(KIND_GLOBAL_HDR);
        w.event_number = 22'h155555;
        w.geo_addr     = '1;
        offer(w);
        w = raw_word(KIND_TDC_HDR);
        w.chip_number = '0;
        w.event_tag   = 12'h555;
        offer(w);
        w = raw_word(KIND_TDC_TRL);
        w.chip_number = '0;
        w.event_tag   = 12'h555;
        w.count_field = 16'd2;
        offer(w);
        w = raw_word(KIND_GLOBAL_TRL);
        w.geo_addr       = '1;
        w.count_field    = 16'd4;
        w.trailer_status = '0;
        offer(w);
        next_evn = 22'h155556;
        cur_geo  = '1;

        // Random part: ask for a long hold-off straight away while traffic flows
        hold_asks++;
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0: offer(raw_word(KIND_W'($urandom)));
                1: send_event(1'b1);
                default: send_event(1'b0);
            endcase
        end
        in_valid <= 1'b0;

        // Drain the block's two stages, then idle briefly before the verdict.
        // Sample the checker's count away from the rising edge.
        @(negedge clk);
        while (still_due != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words: directed frame cases, then %0d random events",
                 words_sent, events_sent);
        $display("%0d result beats checked, %0d mismatches", beats_checked, fault_count);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tesc_pkg.sv
sv/tesc_step.sv
sv/tdc_event_stream_checker_core.sv
sv/tesc_props.sv
verif/tesc_checker.sv
verif/tb_top.sv
